// ===== rtl/lruc_pkg.sv =====
// Shared types, widths and helpers for the two-way LRU cache tag lookup.
// No dependencies; lruc_lookup, lruc_state and the top level import this package.
`default_nettype none

package lruc_pkg;

  localparam int NUM_SETS   = 64;
  localparam int LINE_BYTES = 32;

  localparam int ADDR_W   = 32;
  localparam int OFFSET_W = $clog2(LINE_BYTES);
  localparam int SET_W    = $clog2(NUM_SETS);
  localparam int BLOCK_W  = ADDR_W - OFFSET_W;
  localparam int TAG_W    = BLOCK_W - SET_W;
  localparam int CNT_W    = 32;

  localparam int IN_TDATA_W   = ADDR_W;
  localparam int OUT_RAW_W    = OFFSET_W + BLOCK_W + SET_W + 1 + TAG_W + 1 + 1 + TAG_W
                                + CNT_W + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_RAW_W;

  // Outcome of one tag comparison.
  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             way;
    logic             ev_valid;
    logic [TAG_W-1:0] ev_tag;
  } lruc_dec_t;

  // Tag write issued by the lookup stage, kept for forwarding.
  typedef struct packed {
    logic             vld;
    logic [SET_W-1:0] set;
    logic             way;
    logic [TAG_W-1:0] tag;
  } lruc_wr_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lruc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; depends on nothing.
`default_nettype none

module lruc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Read returns the contents from before a write at the same edge.
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lruc_lookup.sv =====
// Tag comparison against both ways, with forwarding of the previous fill.
// Depends on lruc_pkg.
`default_nettype none

module lruc_lookup (
  input  wire logic [lruc_pkg::SET_W-1:0] set,
  input  wire logic [lruc_pkg::TAG_W-1:0] tag,
  input  wire logic [lruc_pkg::TAG_W-1:0] ram_tag0,
  input  wire logic [lruc_pkg::TAG_W-1:0] ram_tag1,
  input  wire logic                       vld0,
  input  wire logic                       vld1,
  input  wire logic                       lru,
  input  wire lruc_pkg::lruc_wr_t         byp,
  output lruc_pkg::lruc_dec_t             dec
);
  import lruc_pkg::*;

  logic [TAG_W-1:0] tag0;
  logic [TAG_W-1:0] tag1;
  logic             hit0;
  logic             hit1;
  logic             fill_way;

  always_comb begin
    // A fill written at the same edge as our RAM read is not in the read data.
    tag0 = (byp.vld && byp.set == set && !byp.way) ? byp.tag : ram_tag0;
    tag1 = (byp.vld && byp.set == set &&  byp.way) ? byp.tag : ram_tag1;
    hit0 = vld0 && (tag0 == tag);
    hit1 = vld1 && (tag1 == tag);
    fill_way = ~lru;

    dec.hit  = hit0 | hit1;
    dec.miss = ~(hit0 | hit1);
    dec.way  = hit0 ? 1'b0 : (hit1 ? 1'b1 : fill_way);
    dec.ev_valid = dec.miss && (fill_way ? vld1 : vld0);
    if (dec.ev_valid) begin
      dec.ev_tag = fill_way ? tag1 : tag0;
    end else begin
      dec.ev_tag = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lruc_state.sv =====
// Per-set valid and LRU bits in flip-flops, plus the saturating hit and miss counts.
// Depends on lruc_pkg.
`default_nettype none

module lruc_state (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       upd,
  input  wire logic [lruc_pkg::SET_W-1:0] set,
  input  wire lruc_pkg::lruc_dec_t        dec,
  output logic                            vld0,
  output logic                            vld1,
  output logic                            lru,
  output logic [lruc_pkg::CNT_W-1:0]      hit_total,
  output logic [lruc_pkg::CNT_W-1:0]      miss_total
);
  import lruc_pkg::*;

  logic [NUM_SETS-1:0] vld0_r, vld0_nxt;
  logic [NUM_SETS-1:0] vld1_r, vld1_nxt;
  logic [NUM_SETS-1:0] lru_r,  lru_nxt;
  logic [CNT_W-1:0]    hit_r,  hit_nxt;
  logic [CNT_W-1:0]    miss_r, miss_nxt;

  always_comb begin
    vld0 = vld0_r[set];
    vld1 = vld1_r[set];
    lru  = lru_r[set];

    hit_nxt  = dec.hit  ? sat_inc(hit_r)  : hit_r;
    miss_nxt = dec.miss ? sat_inc(miss_r) : miss_r;
    hit_total  = hit_nxt;
    miss_total = miss_nxt;

    vld0_nxt = vld0_r;
    vld1_nxt = vld1_r;
    lru_nxt  = lru_r;
    if (upd) begin
      if (dec.miss && !dec.way) begin
        vld0_nxt[set] = 1'b1;
      end
      if (dec.miss && dec.way) begin
        vld1_nxt[set] = 1'b1;
      end
      lru_nxt[set] = dec.way;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= '0;
      vld1_r <= '0;
      lru_r  <= '1;
      hit_r  <= '0;
      miss_r <= '0;
    end else begin
      vld0_r <= vld0_nxt;
      vld1_r <= vld1_nxt;
      lru_r  <= lru_nxt;
      if (upd) begin
        hit_r  <= hit_nxt;
        miss_r <= miss_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/two_way_lru_cache_tag_lookup_top.sv =====
// Top level of the two-way LRU cache tag lookup.
// Depends on lruc_pkg, lruc_ram, lruc_lookup and lruc_state.
`default_nettype none

// Takes one byte address per transfer and returns one lookup result per address, in order.
// One reference is accepted every cycle unless the output stalls; the address is registered
// at acceptance, when the tag RAMs (one per way, 64 entries) are read, and the compare, LRU
// update and fill happen in the stage after that, before the output register. Valid and LRU
// bits live in flip-flops; reset clears the valid bits and sets the LRU bits, so no clearing
// pass is needed and way 0 of every set is then the first filled. A fill is forwarded
// to a directly following reference to the same set. Hit and miss totals saturate at all ones.
module two_way_lru_cache_tag_lookup_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // address
  input  wire logic [lruc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // byte_offset, block_number, set_index, way_used, tag_value, is_miss,
  // evicted_valid, evicted_tag, hit_total, miss_total, zero padding
  output logic [lruc_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import lruc_pkg::*;

  logic                   in_xfer;
  logic                   s1_adv;
  logic                   s1_vld_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  lruc_wr_t               byp_r;
  lruc_wr_t               wr;
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [SET_W-1:0]       rd_set;
  logic [OFFSET_W-1:0]    s1_offset;
  logic [BLOCK_W-1:0]     s1_block;
  logic [SET_W-1:0]       s1_set;
  logic [TAG_W-1:0]       s1_tag;
  logic [TAG_W-1:0]       ram_tag0;
  logic [TAG_W-1:0]       ram_tag1;
  logic                   vld0;
  logic                   vld1;
  logic                   lru;
  logic [CNT_W-1:0]       hit_total;
  logic [CNT_W-1:0]       miss_total;
  lruc_dec_t              dec;

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  assign rd_set    = in_tdata[OFFSET_W+SET_W-1:OFFSET_W];
  assign s1_offset = s1_addr_r[OFFSET_W-1:0];
  assign s1_block  = s1_addr_r[ADDR_W-1:OFFSET_W];
  assign s1_set    = s1_addr_r[OFFSET_W+SET_W-1:OFFSET_W];
  assign s1_tag    = s1_addr_r[ADDR_W-1:OFFSET_W+SET_W];

  always_comb begin
    wr.vld = s1_adv && dec.miss;
    wr.set = s1_set;
    wr.way = dec.way;
    wr.tag = s1_tag;
  end

  lruc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_SETS)
  ) u_way0_ram (
    .clk     (clk),
    .wr_en   (wr.vld && !wr.way),
    .wr_addr (wr.set),
    .wr_data (wr.tag),
    .rd_en   (in_xfer),
    .rd_addr (rd_set),
    .rd_data (ram_tag0)
  );

  lruc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_SETS)
  ) u_way1_ram (
    .clk     (clk),
    .wr_en   (wr.vld && wr.way),
    .wr_addr (wr.set),
    .wr_data (wr.tag),
    .rd_en   (in_xfer),
    .rd_addr (rd_set),
    .rd_data (ram_tag1)
  );

  lruc_lookup u_lookup (
    .set      (s1_set),
    .tag      (s1_tag),
    .ram_tag0 (ram_tag0),
    .ram_tag1 (ram_tag1),
    .vld0     (vld0),
    .vld1     (vld1),
    .lru      (lru),
    .byp      (byp_r),
    .dec      (dec)
  );

  lruc_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (s1_adv),
    .set        (s1_set),
    .dec        (dec),
    .vld0       (vld0),
    .vld1       (vld1),
    .lru        (lru),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      byp_r     <= '0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      // The forwarded fill must be the one written at the edge the RAMs were read.
      if (in_xfer) begin
        byp_r <= wr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_addr_r <= in_tdata[ADDR_W-1:0];
    end
    if (s1_adv) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, miss_total, hit_total, dec.ev_tag, dec.ev_valid,
                     dec.miss, s1_tag, dec.way, s1_set, s1_block, s1_offset};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
